// ===== rtl/bls_pkg.sv =====
package bls_pkg;

	// list geometry
	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// request and result field widths
	localparam int CMD_W     = 3;
	localparam int VAL_W     = 32;
	localparam int ST_W      = 2;
	localparam int POS_W     = 6;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_REM_FRONT = 3'd2,
		CMD_REM_BACK  = 3'd3,
		CMD_FIND      = 3'd4,
		CMD_REPLACE   = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// what every cell does in the update cycle
	typedef enum logic [2:0] {
		OP_HOLD        = 3'd0,
		OP_SHIFT_RIGHT = 3'd1,
		OP_LOAD_TAIL   = 3'd2,
		OP_SHIFT_LEFT  = 3'd3,
		OP_WRITE_POS   = 3'd4
	} cell_op_t;

	// control broadcast from the sequencer to the row of cells
	typedef struct packed {
		logic             capture;
		logic [VAL_W-1:0] probe;
		cell_op_t         op;
		logic [VAL_W-1:0] new_value;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] pos;
	} cell_ctl_t;

endpackage

// ===== rtl/bls_cmd_if.sv =====
interface bls_cmd_if;
	import bls_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [VAL_W-1:0] value;
	logic [VAL_W-1:0] new_value;

	modport source (output valid, output command, output value, output new_value, input ready);
	modport sink (input valid, input command, input value, input new_value, output ready);

endinterface

// ===== rtl/bls_res_if.sv =====
interface bls_res_if;
	import bls_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ST_W-1:0]      status;
	logic [POS_W-1:0]     match_position;
	logic [CNT_OUT_W-1:0] entry_count;
	logic [VAL_W-1:0]     first_value;
	logic [VAL_W-1:0]     last_value;

	modport source (
		output valid, output status, output match_position, output entry_count,
		output first_value, output last_value, input ready
	);
	modport sink (
		input valid, input status, input match_position, input entry_count,
		input first_value, input last_value, output ready
	);

endinterface

// ===== rtl/bounded_list_with_search.sv =====
// channel | dir | handshake     | payload
// cmd     | in  | valid / ready | command, value, new_value
// res     | out | valid / ready | status, match_position, entry_count,
//         |     |               | first_value, last_value
//
// a new request is taken only after the last one has left the gather step; the
// sequencer steps are compare in all cells, then (find and replace only) a pass
// through the shared first-match encoder, then an update step and a tail gather step
// arst_n clears the sequencer, count, hit flags and result valid; entries hold no reset
// a stalled result sits in the output register while the next request is taken;
// the sequencer waits in the gather step only if that register is still full
module bounded_list_with_search (
	input  logic      clk,
	input  logic      arst_n,
	bls_cmd_if.sink   cmd,
	bls_res_if.source res
);
	import bls_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_FIND   = 4'b0010,
		S_APPLY  = 4'b0100,
		S_GATHER = 4'b1000
	} state_t;

	state_t state_q;

	// captured request
	cmd_t             cmd_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] new_value_q;

	// list state: the cells hold entries in order, front in cell 0
	logic [CNT_W-1:0] count_q;

	// first-match result
	logic             found_q;
	logic [IDX_W-1:0] fpos_q;

	// per-request answer held until gather
	status_t          status_q;
	logic [IDX_W-1:0] mpos_q;

	// output register
	logic                 res_vld_q;
	status_t              res_status_q;
	logic [POS_W-1:0]     res_pos_q;
	logic [CNT_OUT_W-1:0] res_cnt_q;
	logic [VAL_W-1:0]     res_first_q;
	logic [VAL_W-1:0]     res_last_q;

	logic             accept;
	logic             res_free;
	cell_ctl_t        ctl;
	cell_op_t         op_d;
	status_t          status_d;
	logic [CNT_W-1:0] count_d;
	logic [IDX_W-1:0] mpos_d;
	logic             full;
	logic             empty;

	logic [VAL_W-1:0] cell_data [DEPTH];
	logic [VAL_W-1:0] cell_tail [DEPTH];
	logic [DEPTH-1:0] cell_hit;
	logic [VAL_W-1:0] tail_or;
	logic             enc_found;
	logic [IDX_W-1:0] enc_pos;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign res_free  = !res_vld_q || res.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// decode of the captured request in the update cycle
	always_comb begin
		op_d     = OP_HOLD;
		status_d = ST_OK;
		count_d  = count_q;
		mpos_d   = '0;
		unique case (cmd_q)
			CMD_INS_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = OP_SHIFT_RIGHT;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_INS_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = OP_LOAD_TAIL;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REM_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					op_d    = OP_SHIFT_LEFT;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_REM_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_FIND, CMD_REPLACE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (!found_q) begin
					status_d = ST_NOT_FOUND;
				end else begin
					mpos_d = fpos_q;
					if (cmd_q == CMD_REPLACE) begin
						op_d = OP_WRITE_POS;
					end
				end
			end
			default: begin
				// unused codes leave the list alone
				op_d = OP_HOLD;
			end
		endcase
	end

	// broadcast to the cells; the probe doubles as the value to insert
	always_comb begin
		ctl.capture   = accept;
		ctl.probe     = accept ? cmd.value : value_q;
		ctl.op        = (state_q == S_APPLY) ? op_d : OP_HOLD;
		ctl.new_value = new_value_q;
		ctl.count     = count_q;
		ctl.pos       = fpos_q;
	end

	// row of cells, each one shifting with its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_in;
		logic [VAL_W-1:0] right_in;

		if (i == 0) begin : g_head
			assign left_in = value_q;
		end else begin : g_mid_l
			assign left_in = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_in = cell_data[i];
		end else begin : g_mid_r
			assign right_in = cell_data[i+1];
		end

		bls_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.index      (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[i]),
			.hit        (cell_hit[i]),
			.tail       (cell_tail[i])
		);
	end

	bls_prio u_prio (
		.hits  (cell_hit),
		.found (enc_found),
		.pos   (enc_pos)
	);

	// only the back cell drives a nonzero tail
	always_comb begin
		tail_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_or = tail_or | cell_tail[i];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd_t'(cmd.command);
			value_q     <= cmd.value;
			new_value_q <= cmd.new_value;
		end
	end

	// match position and per-request answer
	always_ff @(posedge clk) begin
		if (state_q == S_FIND) begin
			found_q <= enc_found;
			fpos_q  <= enc_pos;
		end
		if (state_q == S_APPLY) begin
			status_q <= status_d;
			mpos_q   <= mpos_d;
		end
	end

	// sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.command == CMD_FIND || cmd.command == CMD_REPLACE) begin
							state_q <= S_FIND;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_FIND: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					count_q <= count_d;
					state_q <= S_GATHER;
				end
				S_GATHER: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == S_GATHER && res_free) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// output register payload, front and back read from the updated cells
	always_ff @(posedge clk) begin
		if (state_q == S_GATHER && res_free) begin
			res_status_q <= status_q;
			res_pos_q    <= POS_W'(mpos_q);
			res_cnt_q    <= CNT_OUT_W'(count_q);
			res_first_q  <= (count_q != '0) ? cell_data[0] : '0;
			res_last_q   <= tail_or;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.status         = res_status_q;
	assign res.match_position = res_pos_q;
	assign res.entry_count    = res_cnt_q;
	assign res.first_value    = res_first_q;
	assign res.last_value     = res_last_q;

endmodule

// ===== rtl/bls_cell.sv =====
module bls_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [bls_pkg::IDX_W-1:0] index,
	input  bls_pkg::cell_ctl_t      ctl,
	input  logic [bls_pkg::VAL_W-1:0] left_data,
	input  logic [bls_pkg::VAL_W-1:0] right_data,
	output logic [bls_pkg::VAL_W-1:0] data,
	output logic                    hit,
	output logic [bls_pkg::VAL_W-1:0] tail
);
	import bls_pkg::*;

	logic [VAL_W-1:0] data_q;
	logic             hit_q;
	logic [CNT_W-1:0] index_w;
	logic             in_range;

	assign index_w  = CNT_W'(index);
	assign in_range = index_w < ctl.count;

	// entry payload, no reset
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_SHIFT_RIGHT: data_q <= left_data;
			OP_SHIFT_LEFT:  data_q <= right_data;
			OP_LOAD_TAIL: begin
				if (index_w == ctl.count) begin
					data_q <= ctl.probe;
				end
			end
			OP_WRITE_POS: begin
				if (index == ctl.pos) begin
					data_q <= ctl.new_value;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	// per-cell compare against the probe value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q <= in_range && (data_q == ctl.probe);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;
	assign tail = (ctl.count == index_w + CNT_W'(1)) ? data_q : '0;

endmodule

// ===== rtl/bls_prio.sv =====
module bls_prio (
	input  logic [bls_pkg::DEPTH-1:0] hits,
	output logic                      found,
	output logic [bls_pkg::IDX_W-1:0] pos
);
	import bls_pkg::*;

	// lowest set hit wins
	always_comb begin
		found = |hits;
		pos   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				pos = IDX_W'(i);
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bls_pkg::*;

	// command codes the block treats as no-ops
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_REQUESTS      = 1300;
	localparam int QUIET_TAIL_LEN       = 150;  // last requests run with no idling at all
	localparam int MISMATCH_PRINT_LIMIT = 10;
	localparam int DRAIN_CYCLES         = 20;   // stray-result watch window, longer than the slowest request

	// one list report, field for field as on the result channel
	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [POS_W-1:0]     match_position;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [VAL_W-1:0]     first_value;
		logic [VAL_W-1:0]     last_value;
	} list_report_t;

	// one line of the directed script; typed lines carry their own answer
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] new_value;
		logic             typed;
		list_report_t     report;
	} script_row_t;

	// flavor of a random phase, steers the list toward full, empty or searches
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_SEARCH,
		MIX_ANY
	} mix_t;

	logic clk;
	logic arst_n;

	bls_cmd_if cmd_bus ();
	bls_res_if res_bus ();

	bounded_list_with_search dut (
		.clk,
		.arst_n,
		.cmd (cmd_bus),
		.res (res_bus)
	);

	// mirror of the list: circular store, front slot and entry count
	logic [VAL_W-1:0] shadow_entries [DEPTH];
	int               shadow_front;
	int               shadow_count;

	list_report_t expected_reports [$];
	script_row_t  directed_script [$];

	int mismatch_count;
	int reports_checked;
	int peak_count;
	int status_tally [4];
	int requests_sent;

	// idling knobs, changed per phase; quiet_tail switches all idling off
	bit quiet_tail;
	int source_gap_pct;
	int sink_stall_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// list behavior for one request: updates the mirror and returns the report
	task automatic predict_list_command(
		input  logic [CMD_W-1:0] code,
		input  logic [VAL_W-1:0] v,
		input  logic [VAL_W-1:0] nv,
		output list_report_t     rpt
	);
		int hit;
		rpt = '0;
		rpt.status = ST_OK;
		hit = -1;
		case (code)
			CMD_INS_FRONT: begin
				if (shadow_count >= DEPTH) begin
					rpt.status = ST_FULL;
				end else begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_entries[shadow_front] = v;
					shadow_count++;
				end
			end
			CMD_INS_BACK: begin
				if (shadow_count >= DEPTH) begin
					rpt.status = ST_FULL;
				end else begin
					shadow_entries[(shadow_front + shadow_count) % DEPTH] = v;
					shadow_count++;
				end
			end
			CMD_REM_FRONT: begin
				if (shadow_count == 0) begin
					rpt.status = ST_EMPTY;
				end else begin
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end
			end
			CMD_REM_BACK: begin
				if (shadow_count == 0)
					rpt.status = ST_EMPTY;
				else
					shadow_count--;
			end
			CMD_FIND, CMD_REPLACE: begin
				// first match counted from the front, full 32-bit compare
				for (int k = 0; k < shadow_count; k++)
					if (hit < 0 && shadow_entries[(shadow_front + k) % DEPTH] === v)
						hit = k;
				if (shadow_count == 0) begin
					rpt.status = ST_EMPTY;
				end else if (hit < 0) begin
					rpt.status = ST_NOT_FOUND;
				end else begin
					rpt.match_position = POS_W'(hit);
					if (code == CMD_REPLACE)
						shadow_entries[(shadow_front + hit) % DEPTH] = nv;
				end
			end
			default: begin
				// spare codes leave the list alone and report it as it is
			end
		endcase
		rpt.entry_count = CNT_OUT_W'(shadow_count);
		if (shadow_count != 0) begin
			rpt.first_value = shadow_entries[shadow_front];
			rpt.last_value  = shadow_entries[(shadow_front + shadow_count - 1) % DEPTH];
		end
		status_tally[rpt.status]++;
		if (shadow_count > peak_count)
			peak_count = shadow_count;
	endtask

	// drive one request from a falling edge, hold it until taken, log its report
	task automatic issue_request(
		input logic [CMD_W-1:0] code,
		input logic [VAL_W-1:0] v,
		input logic [VAL_W-1:0] nv,
		input logic             typed,
		input list_report_t     typed_report
	);
		list_report_t predicted;
		// optional gap before the request, with valid low
		if (!quiet_tail && $urandom_range(0, 99) < source_gap_pct) begin
			cmd_bus.valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		cmd_bus.valid     = 1'b1;
		cmd_bus.command   = code;
		cmd_bus.value     = v;
		cmd_bus.new_value = nv;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		// request taken at this edge
		predict_list_command(code, v, nv, predicted);
		expected_reports.push_back(typed ? typed_report : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// script line with its report typed in
	task automatic add_row(
		input logic [CMD_W-1:0] code,
		input logic [VAL_W-1:0] v,
		input logic [VAL_W-1:0] nv,
		input logic [ST_W-1:0]  st,
		input int               pos,
		input int               cnt,
		input logic [VAL_W-1:0] f,
		input logic [VAL_W-1:0] l
	);
		script_row_t row;
		row.command               = code;
		row.value                 = v;
		row.new_value             = nv;
		row.typed                 = 1'b1;
		row.report.status         = st;
		row.report.match_position = POS_W'(pos);
		row.report.entry_count    = CNT_OUT_W'(cnt);
		row.report.first_value    = f;
		row.report.last_value     = l;
		directed_script.push_back(row);
	endtask

	// script line left to the mirror
	task automatic add_open_row(
		input logic [CMD_W-1:0] code,
		input logic [VAL_W-1:0] v,
		input logic [VAL_W-1:0] nv
	);
		script_row_t row;
		row           = '0;
		row.command   = code;
		row.value     = v;
		row.new_value = nv;
		directed_script.push_back(row);
	endtask

	// command mix per phase flavor: inserts, removes, searches, then spare codes
	function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
		int r;
		int t_ins;
		int t_rem;
		int t_search;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				t_ins = 72; t_rem = 84; t_search = 97;
			end
			MIX_DRAIN: begin
				t_ins = 18; t_rem = 80; t_search = 97;
			end
			MIX_SEARCH: begin
				t_ins = 25; t_rem = 40; t_search = 97;
			end
			default: begin
				t_ins = 30; t_rem = 60; t_search = 96;
			end
		endcase
		if (r < t_ins)
			return $urandom_range(0, 1) ? CMD_INS_FRONT : CMD_INS_BACK;
		else if (r < t_rem)
			return $urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK;
		else if (r < t_search)
			return $urandom_range(0, 1) ? CMD_FIND : CMD_REPLACE;
		else
			return $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
	endfunction

	// values: often one already stored (for hits), a small pool with repeats
	// and extremes (for duplicates and sign edges), or anything at all
	function automatic logic [VAL_W-1:0] pick_value(input bit prefer_present);
		int r;
		r = $urandom_range(0, 99);
		if (prefer_present && shadow_count != 0 && r < 60)
			return shadow_entries[(shadow_front + $urandom_range(0, shadow_count - 1)) % DEPTH];
		if (r < 75) begin
			case ($urandom_range(0, 7))
				0:       return 32'h8000_0000;
				1:       return 32'h7fff_ffff;
				2:       return 32'h0000_0000;
				3:       return 32'hffff_ffff;
				4:       return 32'h0000_0001;
				default: return 32'(100 + $urandom_range(0, 3));
			endcase
		end
		return $urandom();
	endfunction

	// result sink: ready, with random stall bursts
	initial begin
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct) begin
				res_bus.ready = 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				res_bus.ready = 1'b1;
			end
		end
	end

	// report checker: every taken result against the oldest expectation
	always @(posedge clk) begin : report_checker
		list_report_t got;
		list_report_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.status         = res_bus.status;
			got.match_position = res_bus.match_position;
			got.entry_count    = res_bus.entry_count;
			got.first_value    = res_bus.first_value;
			got.last_value     = res_bus.last_value;
			if (expected_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MISMATCH_PRINT_LIMIT)
					$display("%0t: result with nothing outstanding: st=%0d pos=%0d cnt=%0d",
						$realtime, got.status, got.match_position, got.entry_count);
			end else begin
				want = expected_reports.pop_front();
				reports_checked++;
				if (got.status !== want.status ||
					got.match_position !== want.match_position ||
					got.entry_count !== want.entry_count ||
					got.first_value !== want.first_value ||
					got.last_value !== want.last_value) begin
					mismatch_count++;
					if (mismatch_count <= MISMATCH_PRINT_LIMIT) begin
						$display("%0t: report %0d mismatch", $realtime, reports_checked);
						$display("  expected st=%0d pos=%0d cnt=%0d first=%h last=%h",
							want.status, want.match_position, want.entry_count,
							want.first_value, want.last_value);
						$display("  actual   st=%0d pos=%0d cnt=%0d first=%h last=%h",
							got.status, got.match_position, got.entry_count,
							got.first_value, got.last_value);
					end
				end
			end
		end
	end

	// hard stop if the block hangs
	initial begin
		#4_000_000;
		$display("timeout with %0d reports outstanding", expected_reports.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		mix_t             mix;
		int               phase_len;
		int               sent;
		logic [CMD_W-1:0] code;
		logic [VAL_W-1:0] v;

		// known values on every input from time zero
		arst_n            = 1'b0;
		cmd_bus.valid     = 1'b0;
		cmd_bus.command   = CMD_INS_FRONT;
		cmd_bus.value     = '0;
		cmd_bus.new_value = '0;
		quiet_tail        = 1'b0;
		source_gap_pct    = 0;
		sink_stall_pct    = 0;
		shadow_front      = 0;
		shadow_count      = 0;
		mismatch_count    = 0;
		reports_checked   = 0;
		peak_count        = 0;
		requests_sent     = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed script: empty-list errors, spare codes, one-entry removes,
		// sign extremes at both ends, first match among duplicates, misses
		add_row(CMD_REM_FRONT, 0, 0, ST_EMPTY, 0, 0, 0, 0);
		add_row(CMD_REM_BACK, 0, 0, ST_EMPTY, 0, 0, 0, 0);
		add_row(CMD_FIND, 0, 0, ST_EMPTY, 0, 0, 0, 0);
		add_row(CMD_REPLACE, 0, 5, ST_EMPTY, 0, 0, 0, 0);
		add_row(CMD_SPARE_LO, 0, 0, ST_OK, 0, 0, 0, 0);
		add_row(CMD_INS_FRONT, 32'h7fff_ffff, 0, ST_OK, 0, 1, 32'h7fff_ffff, 32'h7fff_ffff);
		add_row(CMD_REM_BACK, 0, 0, ST_OK, 0, 0, 0, 0);
		add_row(CMD_INS_BACK, 32'h8000_0000, 0, ST_OK, 0, 1, 32'h8000_0000, 32'h8000_0000);
		add_row(CMD_REM_FRONT, 0, 0, ST_OK, 0, 0, 0, 0);
		add_row(CMD_INS_BACK, 0, 0, ST_OK, 0, 1, 0, 0);
		add_row(CMD_INS_BACK, 32'hffff_ffff, 0, ST_OK, 0, 2, 0, 32'hffff_ffff);
		add_open_row(CMD_INS_FRONT, 32'h8000_0000, 0);
		add_open_row(CMD_FIND, 32'hffff_ffff, 0);
		add_row(CMD_FIND, 32'h7fff_ffff, 0, ST_NOT_FOUND, 0, 3, 32'h8000_0000, 32'hffff_ffff);
		add_open_row(CMD_REPLACE, 0, 32'h7fff_ffff);
		add_open_row(CMD_FIND, 32'h7fff_ffff, 0);
		add_open_row(CMD_INS_BACK, 32'h8000_0000, 0);
		add_open_row(CMD_FIND, 32'h8000_0000, 0);
		add_open_row(CMD_REPLACE, 32'h8000_0000, 32'h5a5a_5a5a);
		add_open_row(CMD_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff);
		add_open_row(CMD_REPLACE, 32'hffff_ffff, 0);
		add_open_row(CMD_REM_BACK, 0, 0);
		add_open_row(CMD_REM_FRONT, 0, 0);
		add_open_row(CMD_REM_FRONT, 0, 0);
		add_open_row(CMD_REM_FRONT, 0, 0);

		source_gap_pct = 30;
		sink_stall_pct = 30;
		foreach (directed_script[i])
			issue_request(directed_script[i].command, directed_script[i].value,
				directed_script[i].new_value, directed_script[i].typed,
				directed_script[i].report);

		// random phases; fill phases run into the full list, drain phases
		// back to empty, search phases hit deep positions
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			mix       = mix_t'($urandom_range(0, 3));
			phase_len = $urandom_range(40, 160);
			case ($urandom_range(0, 2))
				0:       source_gap_pct = 0;
				1:       source_gap_pct = 8;
				default: source_gap_pct = 35;
			endcase
			case ($urandom_range(0, 2))
				0:       sink_stall_pct = 0;
				1:       sink_stall_pct = 8;
				default: sink_stall_pct = 35;
			endcase
			for (int i = 0; i < phase_len && sent < RANDOM_REQUESTS; i++) begin
				quiet_tail = (RANDOM_REQUESTS - sent) <= QUIET_TAIL_LEN;
				code = pick_command(mix);
				v    = pick_value(code == CMD_FIND || code == CMD_REPLACE);
				issue_request(code, v, $urandom(), 1'b0, '0);
				sent++;
			end
		end
		cmd_bus.valid = 1'b0;

		// let outstanding reports come back, then watch for strays
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d reports compared, %0d mismatches, peak count %0d of %0d",
			requests_sent, reports_checked, mismatch_count, peak_count, DEPTH);
		$display("status mix: ok %0d, empty %0d, not found %0d, full %0d",
			status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_NOT_FOUND],
			status_tally[ST_FULL]);
		if (mismatch_count == 0 && expected_reports.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bls_pkg.sv
rtl/bls_cmd_if.sv
rtl/bls_res_if.sv
rtl/bls_cell.sv
rtl/bls_prio.sv
rtl/bounded_list_with_search.sv
tb/testbench.sv
